FILE: sv/rhc_pkg.sv
package rhc_pkg;
    localparam int unsigned HueW = 9;
    localparam logic CMD_TO_HSV = 1'b0;
    localparam logic CMD_TO_RGB = 1'b1;
endpackage

FILE: sv/rgb_hsv_converter_unit.sv
// RGB <-> HSV color converter, 8-bit channels.
// Input channel: in_valid/in_ready carry one request (command plus all fields).
// command 0 converts red/green/blue to hue/sat/val; command 1 converts
// hue/sat/val (hue signed, wrapped mod 360) to red/green/blue and copies alpha.
// Unused result fields read as zero.
// Output channel: out_valid/out_ready carry one result per request, in order.
// Throughput: one request per cycle unless out_ready stalls the pipeline.
// The hue and saturation quotients use a restoring divider unrolled across
// stages 3 to 5: three hue quotient bits per stage, and three, three and two
// saturation quotient bits.
// Reset clears every valid bit; payload registers are not reset.
// When out_ready is low and the last stage is full the whole pipeline holds, and
// in_ready drops only in that case, so nothing is lost or repeated.
module rgb_hsv_converter_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [7:0]                   red_in,
    input  logic [7:0]                   green_in,
    input  logic [7:0]                   blue_in,
    input  logic signed [15:0]           hue_in,
    input  logic [7:0]                   sat_in,
    input  logic [7:0]                   val_in,
    input  logic [7:0]                   alpha_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   red_out,
    output logic [7:0]                   green_out,
    output logic [7:0]                   blue_out,
    output logic [7:0]                   alpha_out,
    output logic [rhc_pkg::HueW-1:0]     hue_out,
    output logic [7:0]                   sat_out,
    output logic [7:0]                   val_out
);
    import rhc_pkg::*;

    localparam int NS = 6;

    // restoring division steps for the hue quotient, bits hi down to lo
    function automatic logic [25:0] hue_div_step(logic [16:0] rem, logic [8:0] quo,
                                                 logic [7:0] dv, int hi, int lo);
        logic [16:0] r;
        logic [8:0]  q;
        r = rem;
        q = quo;
        for (int i = hi; i >= lo; i--)
        begin
            if (r >= (17'(dv) << i))
            begin
                r    = r - (17'(dv) << i);
                q[i] = 1'b1;
            end
        end
        return {q, r};
    endfunction

    // restoring division steps for the saturation quotient
    function automatic logic [25:0] sat_div_step(logic [17:0] rem, logic [7:0] quo,
                                                 logic [8:0] dv, int hi, int lo);
        logic [17:0] r;
        logic [7:0]  q;
        r = rem;
        q = quo;
        for (int i = hi; i >= lo; i--)
        begin
            if (r >= (18'(dv) << i))
            begin
                r    = r - (18'(dv) << i);
                q[i] = 1'b1;
            end
        end
        return {q, r};
    endfunction

    // pipeline control: whole pipe advances when the tail can move
    logic [NS-1:0] vld_reg;
    logic          adv;
    assign adv       = !vld_reg[NS-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // ---------------- stage 1: min/max, hue offset ----------------
    logic        c1_reg;
    logic [7:0]  mx1_reg, dl1_reg, a1_reg, s1_reg, v1_reg;
    logic signed [11:0] hn1_reg;   // sextant numerator over 60, -255..1275
    logic [16:0] hoff1_reg;
    logic [7:0]  mx_c, mn_c, dl_c;
    logic signed [11:0] hn_c;
    logic [16:0] hoff_c;

    always_comb
    begin
        mx_c = red_in;
        mn_c = red_in;
        if (green_in > mx_c) mx_c = green_in;
        if (blue_in  > mx_c) mx_c = blue_in;
        if (green_in < mn_c) mn_c = green_in;
        if (blue_in  < mn_c) mn_c = blue_in;
        dl_c = mx_c - mn_c;
        if (red_in >= mx_c)
            hn_c = signed'({4'b0, green_in}) - signed'({4'b0, blue_in});
        else if (green_in >= mx_c)
            hn_c = signed'({3'b0, dl_c, 1'b0})
                 + signed'({4'b0, blue_in}) - signed'({4'b0, red_in});
        else
            hn_c = signed'({2'b0, dl_c, 2'b0})
                 + signed'({4'b0, red_in}) - signed'({4'b0, green_in});
        // 33120 = 92*360 makes the hue non-negative without changing it mod 360
        hoff_c = 17'(hue_in) + 17'd33120;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg    <= command;
            mx1_reg   <= mx_c;
            dl1_reg   <= dl_c;
            hn1_reg   <= hn_c;
            hoff1_reg <= hoff_c;
            s1_reg    <= sat_in;
            v1_reg    <= val_in;
            a1_reg    <= alpha_in;
        end
    end

    // ---------------- stage 2: numerators, hue mod 360 ----------------
    // hsv: hue numerator 60*hn (+360*delta), sat numerator 510*delta+max
    // rgb: floor(x/360) by reciprocal 93207/2^25, exact for x < 2^18
    logic        c2_reg;
    logic [7:0]  mx2_reg, dl2_reg, a2_reg, s2_reg, v2_reg;
    logic [16:0] hnum2_reg;
    logic [17:0] snum2_reg;
    logic [8:0]  hh2_reg;
    logic signed [17:0] hs_c;
    logic [33:0] hprod_c;
    logic [8:0]  hh_c;

    always_comb
    begin
        hs_c = 18'(hn1_reg) * 18'sd60;
        if (hs_c < 0) hs_c = hs_c + 18'(signed'({10'b0, dl1_reg})) * 18'sd360;
        hprod_c = 34'(hoff1_reg) * 34'd93207;
        hh_c    = 9'(hoff1_reg - 17'(hprod_c[33:25]) * 17'd360);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg    <= c1_reg;
            mx2_reg   <= mx1_reg;
            dl2_reg   <= dl1_reg;
            a2_reg    <= a1_reg;
            s2_reg    <= s1_reg;
            v2_reg    <= v1_reg;
            hnum2_reg <= hs_c[16:0];
            snum2_reg <= 18'(dl1_reg) * 18'd510 + 18'(mx1_reg);
            hh2_reg   <= hh_c;
        end
    end

    // ---------------- stage 3: sextant, products; first quotient bits -------
    logic        c3_reg;
    logic [7:0]  mx3_reg, dl3_reg, a3_reg, v3_reg;
    logic [16:0] hr3_reg;
    logic [8:0]  hq3_reg;
    logic [17:0] sr3_reg;
    logic [7:0]  sq3_reg;
    logic [2:0]  sx3_reg;
    logic [15:0] pn3_reg;
    logic [13:0] sf3_reg, sg3_reg;
    logic [5:0]  f_c;
    logic [2:0]  sx_c;
    logic [25:0] hd3_c, sd3_c;

    always_comb
    begin
        if (hh2_reg >= 9'd300)      sx_c = 3'd5;
        else if (hh2_reg >= 9'd240) sx_c = 3'd4;
        else if (hh2_reg >= 9'd180) sx_c = 3'd3;
        else if (hh2_reg >= 9'd120) sx_c = 3'd2;
        else if (hh2_reg >= 9'd60)  sx_c = 3'd1;
        else                        sx_c = 3'd0;
        f_c = 6'(hh2_reg - 9'(sx_c) * 9'd60);
    end

    assign hd3_c = hue_div_step(hnum2_reg, 9'd0, dl2_reg, 8, 6);
    assign sd3_c = sat_div_step(snum2_reg, 8'd0, {mx2_reg, 1'b0}, 7, 5);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c3_reg  <= c2_reg;
            mx3_reg <= mx2_reg;
            dl3_reg <= dl2_reg;
            a3_reg  <= a2_reg;
            v3_reg  <= v2_reg;
            hr3_reg <= hd3_c[16:0];
            hq3_reg <= hd3_c[25:17];
            sr3_reg <= sd3_c[17:0];
            sq3_reg <= sd3_c[25:18];
            sx3_reg <= sx_c;
            pn3_reg <= v2_reg * (8'd255 - s2_reg);
            sf3_reg <= 14'(s2_reg) * 14'(f_c);
            sg3_reg <= 14'(s2_reg) * 14'(6'd60 - f_c);
        end
    end

    // ---------------- stage 4: p, q/t numerators; middle quotient bits ------
    logic        c4_reg;
    logic [7:0]  mx4_reg, dl4_reg, a4_reg, v4_reg, p4_reg;
    logic [16:0] hr4_reg;
    logic [8:0]  hq4_reg;
    logic [17:0] sr4_reg;
    logic [7:0]  sq4_reg;
    logic [2:0]  sx4_reg;
    logic [21:0] qn4_reg, tn4_reg;
    logic [25:0] hd4_c, sd4_c;

    assign hd4_c = hue_div_step(hr3_reg, hq3_reg, dl3_reg, 5, 3);
    assign sd4_c = sat_div_step(sr3_reg, sq3_reg, {mx3_reg, 1'b0}, 4, 2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c4_reg  <= c3_reg;
            mx4_reg <= mx3_reg;
            dl4_reg <= dl3_reg;
            a4_reg  <= a3_reg;
            v4_reg  <= v3_reg;
            hr4_reg <= hd4_c[16:0];
            hq4_reg <= hd4_c[25:17];
            sr4_reg <= sd4_c[17:0];
            sq4_reg <= sd4_c[25:18];
            sx4_reg <= sx3_reg;
            // divide by 255: (x + 1 + (x>>8)) >> 8 exact for x < 65536
            p4_reg  <= 8'((17'(pn3_reg) + 17'd1 + 17'(pn3_reg[15:8])) >> 8);
            qn4_reg <= 22'(v3_reg) * 22'(14'd15300 - sf3_reg);
            tn4_reg <= 22'(v3_reg) * 22'(14'd15300 - sg3_reg);
        end
    end

    // ---------------- stage 5: q,t over 60; last quotient bits --------------
    // x/60 = (x>>2)/15, by reciprocal 1118482/2^24, exact for x>>2 < 2^20
    logic        c5_reg;
    logic [7:0]  mx5_reg, dl5_reg, a5_reg, v5_reg, p5_reg, sat5_reg;
    logic [8:0]  hue5_reg;
    logic [2:0]  sx5_reg;
    logic [15:0] qd5_reg, td5_reg;
    logic [40:0] qprod_c, tprod_c;
    logic [25:0] hd5_c, sd5_c;

    assign hd5_c   = hue_div_step(hr4_reg, hq4_reg, dl4_reg, 2, 0);
    assign sd5_c   = sat_div_step(sr4_reg, sq4_reg, {mx4_reg, 1'b0}, 1, 0);
    assign qprod_c = 41'(qn4_reg[21:2]) * 41'd1118482;
    assign tprod_c = 41'(tn4_reg[21:2]) * 41'd1118482;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c5_reg   <= c4_reg;
            mx5_reg  <= mx4_reg;
            dl5_reg  <= dl4_reg;
            a5_reg   <= a4_reg;
            v5_reg   <= v4_reg;
            p5_reg   <= p4_reg;
            sx5_reg  <= sx4_reg;
            hue5_reg <= hd5_c[25:17];
            sat5_reg <= sd5_c[25:18];
            qd5_reg  <= 16'(qprod_c >> 24);
            td5_reg  <= 16'(tprod_c >> 24);
        end
    end

    // ---------------- stage 6: q,t over 255, sextant select, output ---------
    logic [7:0] q_c, t_c, r_c, g_c, b_c;

    always_comb
    begin
        q_c = 8'((17'(qd5_reg) + 17'd1 + 17'(qd5_reg[15:8])) >> 8);
        t_c = 8'((17'(td5_reg) + 17'd1 + 17'(td5_reg[15:8])) >> 8);
        case (sx5_reg)
            3'd0:    begin r_c = v5_reg; g_c = t_c;    b_c = p5_reg; end
            3'd1:    begin r_c = q_c;    g_c = v5_reg; b_c = p5_reg; end
            3'd2:    begin r_c = p5_reg; g_c = v5_reg; b_c = t_c;    end
            3'd3:    begin r_c = p5_reg; g_c = q_c;    b_c = v5_reg; end
            3'd4:    begin r_c = t_c;    g_c = p5_reg; b_c = v5_reg; end
            default: begin r_c = v5_reg; g_c = p5_reg; b_c = q_c;    end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (c5_reg == CMD_TO_RGB)
            begin
                red_out   <= r_c;
                green_out <= g_c;
                blue_out  <= b_c;
                alpha_out <= a5_reg;
                hue_out   <= '0;
                sat_out   <= '0;
                val_out   <= '0;
            end
            else
            begin
                red_out   <= '0;
                green_out <= '0;
                blue_out  <= '0;
                alpha_out <= '0;
                val_out   <= mx5_reg;
                // grey input: hue and saturation are zero
                if (dl5_reg == '0)
                begin
                    hue_out <= '0;
                    sat_out <= '0;
                end
                else
                begin
                    hue_out <= (hue5_reg >= 9'd360) ? hue5_reg - 9'd360 : hue5_reg;
                    sat_out <= sat5_reg;
                end
            end
        end
    end
endmodule

FILE: test/rgb_hsv_converter_checker.sv
`timescale 1ns / 100ps

module rgb_hsv_converter_checker
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     command,
    input  logic [7:0]               red_in,
    input  logic [7:0]               green_in,
    input  logic [7:0]               blue_in,
    input  logic signed [15:0]       hue_in,
    input  logic [7:0]               sat_in,
    input  logic [7:0]               val_in,
    input  logic [7:0]               alpha_in,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [7:0]               red_out,
    input  logic [7:0]               green_out,
    input  logic [7:0]               blue_out,
    input  logic [7:0]               alpha_out,
    input  logic [rhc_pkg::HueW-1:0] hue_out,
    input  logic [7:0]               sat_out,
    input  logic [7:0]               val_out,
    output int                       fail_count,
    output int                       pending
);
    import rhc_pkg::*;

    typedef struct packed {
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [7:0]      alpha;
        logic [HueW-1:0] hue;
        logic [7:0]      sat;
        logic [7:0]      val;
    } color_t;

    color_t expected_colors[$];

    // rgb to hsv, exact integer form
    function automatic color_t rgb_to_hsv(int r, int g, int b);
        color_t c;
        int mx, mn, d, num, h, s;
        c = '0;
        mx = r;
        mn = r;
        h = 0;
        s = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d > 0)
        begin
            s = (510 * d + mx) / (2 * mx);
            if (r >= mx) num = 60 * (g - b);
            else if (g >= mx) num = 60 * (2 * d + (b - r));
            else num = 60 * (4 * d + (r - g));
            if (num < 0) num += 360 * d;
            h = num / d;
            if (h >= 360) h -= 360;
        end
        c.hue = h[HueW-1:0];
        c.sat = s[7:0];
        c.val = mx[7:0];
        return c;
    endfunction

    function automatic logic [7:0] clamp_byte(int x);
        if (x < 0) return 8'd0;
        if (x > 255) return 8'd255;
        return x[7:0];
    endfunction

    // hsv to rgb by sextant
    function automatic color_t hsv_to_rgb(int h, int s, int v, logic [7:0] a);
        color_t c;
        int hh, f, p, q, t, rr, gg, bb;
        c = '0;
        hh = h % 360;
        if (hh < 0) hh += 360;
        f = hh % 60;
        p = (v * (255 - s)) / 255;
        q = (v * (15300 - s * f)) / 15300;
        t = (v * (15300 - s * (60 - f))) / 15300;
        case (hh / 60)
            0: begin rr = v; gg = t; bb = p; end
            1: begin rr = q; gg = v; bb = p; end
            2: begin rr = p; gg = v; bb = t; end
            3: begin rr = p; gg = q; bb = v; end
            4: begin rr = t; gg = p; bb = v; end
            default: begin rr = v; gg = p; bb = q; end
        endcase
        c.red = clamp_byte(rr);
        c.green = clamp_byte(gg);
        c.blue = clamp_byte(bb);
        c.alpha = a;
        return c;
    endfunction

    task automatic report(string name, int exp_v, int act_v);
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        color_t e;
        if (rst_n)
        begin
            // record request
            if (in_valid && in_ready)
            begin
                if (command == CMD_TO_HSV)
                    expected_colors.push_back(rgb_to_hsv(red_in, green_in, blue_in));
                else
                    expected_colors.push_back(hsv_to_rgb(int'(hue_in), sat_in, val_in,
                                                         alpha_in));
            end
            // compare result
            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none", $time);
                    fail_count++;
                end
                else
                begin
                    e = expected_colors.pop_front();
                    if (red_out !== e.red) report("red", e.red, red_out);
                    if (green_out !== e.green) report("green", e.green, green_out);
                    if (blue_out !== e.blue) report("blue", e.blue, blue_out);
                    if (alpha_out !== e.alpha) report("alpha", e.alpha, alpha_out);
                    if (hue_out !== e.hue) report("hue", e.hue, hue_out);
                    if (sat_out !== e.sat) report("sat", e.sat, sat_out);
                    if (val_out !== e.val) report("val", e.val, val_out);
                end
            end
        end
        pending = expected_colors.size();
    end
endmodule

FILE: test/tb_rgb_hsv_converter_unit.sv
`timescale 1ns / 100ps

module tb_rgb_hsv_converter_unit;
    import rhc_pkg::*;

    localparam int CycleLimit = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic command;
    logic [7:0] red_in, green_in, blue_in, sat_in, val_in, alpha_in;
    logic signed [15:0] hue_in;
    logic out_valid;
    logic out_ready;
    logic [7:0] red_out, green_out, blue_out, alpha_out, sat_out, val_out;
    logic [HueW-1:0] hue_out;
    int fail_count;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    rgb_hsv_converter_unit dut (.*);
    rgb_hsv_converter_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // present one request and wait until it is taken
    task automatic send_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [15:0] h, logic [7:0] s, logic [7:0] v,
                                logic [7:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        hue_in <= h;
        sat_in <= s;
        val_in <= v;
        alpha_in <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [15:0] h;
        int k;
        for (k = 0; k < count; k++)
        begin
            h = 16'($urandom);
            if ($urandom_range(1)) h = 16'($urandom_range(719) - 360);
            send_request(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom),
                         h, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = CMD_TO_HSV;
        {red_in, green_in, blue_in, sat_in, val_in, alpha_in} = '0;
        hue_in = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: greys, primaries, ties, hue wrap extremes
        send_request(CMD_TO_HSV, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd255, 8'd255, 8'd255, 16'hffff, 8'hff, 8'hff, 8'hff);
        send_request(CMD_TO_HSV, 8'd255, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd0, 8'd255, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd0, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd255, 8'd255, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd0, 8'd255, 8'd255, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd255, 8'd0, 8'd1, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_HSV, 8'd1, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 16'sd0, 8'd255, 8'd255, 8'd0);
        send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 16'sd359, 8'd255, 8'd255, 8'd255);
        send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 16'sd360, 8'd0, 8'd255, 8'd1);
        send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, -16'sd1, 8'd255, 8'd128, 8'd2);
        send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 16'h8000, 8'd200, 8'd255, 8'd3);
        send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 16'h7fff, 8'd255, 8'd0, 8'd4);
        for (k = 0; k < 6; k++)
            send_request(CMD_TO_RGB, 8'd0, 8'd0, 8'd0, 16'(k * 60 + 30), 8'd255,
                         8'd255, 8'(k));

        // random phases with varied stalls
        send_idle_pct = 37;
        recv_idle_pct = 85;
        send_random(200);
        send_idle_pct = 85;
        recv_idle_pct = 37;
        send_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(200);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
